>>> design/lru_byte_budget_cache_manager_top_defines.svh
// Assertion macros for the byte-budget cache manager.
// Included by the top level; depends on nothing else.
`ifndef LRU_BYTE_BUDGET_CACHE_MANAGER_TOP_DEFINES_SVH
`define LRU_BYTE_BUDGET_CACHE_MANAGER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LRUBB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrubb assertion failed");
`define LRUBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrubb assertion failed");
`else
`define LRUBB_ASSERT_NOW(label, clk, rst, ante, cons)
`define LRUBB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/lrubb_pkg.sv
// Shared types and constants of the byte-budget cache manager.
// Used by the recency cell, the cell chain and the top level.
package lrubb_pkg;

  localparam int ENTRIES = 32;
  localparam int ENTRY_W = 5;
  localparam int BYTES_W = 24;
  localparam int TOTAL_W = 40;
  localparam int CMP_W   = TOTAL_W + 4;

  typedef enum logic [2:0] {
    CMD_TOUCH   = 3'd0,
    CMD_RESERVE = 3'd1,
    CMD_OK      = 3'd2,
    CMD_FAIL    = 3'd3,
    CMD_UNLOAD  = 3'd4
  } lrubb_cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_DUP     = 2'd2,
    STATUS_EVICT   = 2'd3
  } lrubb_status_t;

  // One slot of the recency row: valid and the entry index it holds.
  typedef struct packed {
    logic               valid;
    logic [ENTRY_W-1:0] idx;
  } lrubb_slot_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic               push;
    logic               remove;
    logic               pop_tail;
    logic [ENTRY_W-1:0] key;
  } lrubb_cell_op_t;

endpackage

>>> design/lrubb_cell.sv
// One position of the recency row: holds one slot and trades it with neighbors.
// Depends on lrubb_pkg.
module lrubb_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  lrubb_pkg::lrubb_cell_op_t op,
  input  lrubb_pkg::lrubb_slot_t prev_slot,
  input  lrubb_pkg::lrubb_slot_t next_slot,
  input  logic                   hit_in,
  output logic                   hit_out,
  output lrubb_pkg::lrubb_slot_t slot
);
  import lrubb_pkg::*;

  logic hit;

  assign hit     = slot.valid && (slot.idx == op.key);
  assign hit_out = hit_in | hit;

  // Push shifts every cell up to and including the matching one toward the
  // tail; remove pulls every cell from the match onward toward the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (op.push) begin
      if (!hit_in) begin
        slot <= prev_slot;
      end
    end else if (op.remove) begin
      if (hit_out) begin
        slot <= next_slot;
      end
    end else if (op.pop_tail) begin
      slot.valid <= slot.valid & next_slot.valid;
    end
  end

endmodule

>>> design/lrubb_chain.sv
// Row of recency cells, most recent entry at the head.
// Depends on lrubb_pkg and lrubb_cell.
module lrubb_chain (
  input  logic                           clk,
  input  logic                           rst,
  input  lrubb_pkg::lrubb_cell_op_t      op,
  output logic                           nonempty,
  output logic [lrubb_pkg::ENTRY_W-1:0]  tail_idx
);
  import lrubb_pkg::*;

  lrubb_slot_t slots [ENTRIES];
  lrubb_slot_t prev_in [ENTRIES];
  lrubb_slot_t next_in [ENTRIES];
  logic        hit_chain [ENTRIES+1];
  logic [ENTRY_W-1:0] tail_part [ENTRIES];

  assign hit_chain[0] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign prev_in[i] = '{valid: 1'b1, idx: op.key};
      end else begin : g_body
        assign prev_in[i] = slots[i-1];
      end
      if (i == ENTRIES - 1) begin : g_end
        assign next_in[i] = '{valid: 1'b0, idx: '0};
      end else begin : g_mid
        assign next_in[i] = slots[i+1];
      end

      lrubb_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .op        (op),
        .prev_slot (prev_in[i]),
        .next_slot (next_in[i]),
        .hit_in    (hit_chain[i]),
        .hit_out   (hit_chain[i+1]),
        .slot      (slots[i])
      );

      assign tail_part[i] = (slots[i].valid && !next_in[i].valid) ? slots[i].idx : '0;
    end
  endgenerate

  assign nonempty = slots[0].valid;

  // Exactly one cell is the tail of a nonempty row.
  always_comb begin
    tail_idx = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      tail_idx = tail_idx | tail_part[k];
    end
  end

endmodule

>>> design/lru_byte_budget_cache_manager_top.sv
// Top level of the byte-budget cache manager: command sequencer, size memory.
// Depends on lrubb_pkg, lrubb_chain and the assertion macro header.
`include "lru_byte_budget_cache_manager_top_defines.svh"

// A command is taken when start is high and busy is low. Touch, complete, fail
// and unload give one result, registered through the execute state, and keep
// busy high only there. Reserve gives one eviction report per evicted entry
// and then its final result; each eviction needs a budget compare and tail pick
// in the trim state and then the registered size-memory read and relink of the
// recency row in the evict state, which reports the evicted entry.
// Results appear for one cycle under done and must be taken then; busy stays
// high until the final result (last) shows, and the next command can be taken
// in that same cycle. The budget write port is always ready.
module lru_byte_budget_cache_manager_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     command,
  input  logic [lrubb_pkg::ENTRY_W-1:0]  entry,
  input  logic [lrubb_pkg::BYTES_W-1:0]  entry_bytes,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrubb_pkg::TOTAL_W-1:0]  cfg_data,
  output logic                           done,
  output logic [1:0]                     status,
  output logic                           evicted_valid,
  output logic [lrubb_pkg::ENTRY_W-1:0]  evicted_entry,
  output logic [lrubb_pkg::TOTAL_W-1:0]  total_bytes,
  output logic                           last
);
  import lrubb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_TRIM  = 4'b0100,
    ST_EVICT = 4'b1000
  } state_t;

  state_t               state;
  logic [2:0]           cmd_r;
  logic [ENTRY_W-1:0]   entry_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic [ENTRY_W-1:0]   tail_r;
  logic [ENTRIES-1:0]   resident;
  logic [ENTRIES-1:0]   pending;
  logic [TOTAL_W-1:0]   byte_total;
  logic [CMP_W-1:0]     budget_x9;

  logic [BYTES_W-1:0]   size_mem [ENTRIES];
  logic [BYTES_W-1:0]   rd_data;
  logic [ENTRY_W-1:0]   rd_addr;
  logic                 mem_we;

  lrubb_cell_op_t       op;
  logic                 nonempty;
  logic [ENTRY_W-1:0]   tail_idx;

  logic                 cmd_ok;
  logic                 res_hit;
  logic                 pend_hit;
  logic                 trim_go;
  logic [CMP_W-1:0]     total_x10;
  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   total_add;
  logic [TOTAL_W-1:0]   total_sub;

  assign busy        = (state != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign total_bytes = byte_total;

  assign cmd_ok   = (cmd_r <= CMD_UNLOAD) && ({1'b0, entry_r} < (ENTRY_W+1)'(ENTRIES));
  assign res_hit  = resident[entry_r];
  assign pend_hit = pending[entry_r];

  assign total_x10 = {1'b0, byte_total, 3'b000} + {3'b000, byte_total, 1'b0};
  assign trim_go   = nonempty && (total_x10 > budget_x9);

  assign sum       = {1'b0, byte_total} + (TOTAL_W+1)'(bytes_r);
  assign total_add = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  assign total_sub = (TOTAL_W'(rd_data) > byte_total) ? '0 : byte_total - TOTAL_W'(rd_data);

  always_comb begin
    op          = '0;
    op.key      = entry_r;
    case (state)
      ST_EXEC: begin
        if (cmd_ok) begin
          op.push   = ((cmd_r == CMD_TOUCH) && res_hit) || ((cmd_r == CMD_OK) && pend_hit);
          op.remove = (cmd_r == CMD_UNLOAD) && res_hit;
        end
      end
      ST_EVICT: begin
        op.pop_tail = 1'b1;
      end
      default: begin
        op.push = 1'b0;
      end
    endcase
  end

  lrubb_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .nonempty (nonempty),
    .tail_idx (tail_idx)
  );

  // The size of the addressed entry is read on acceptance, and the size of
  // the tail entry while the trim decision is made.
  assign rd_addr = (state == ST_TRIM) ? tail_idx : entry;
  assign mem_we  = (state == ST_TRIM) && !trim_go;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[entry_r] <= bytes_r;
    end
    rd_data <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      resident   <= '0;
      pending    <= '0;
      byte_total <= '0;
      budget_x9  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        budget_x9 <= {1'b0, cfg_data, 3'b000} + CMP_W'(cfg_data);
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_r   <= command;
            entry_r <= entry;
            bytes_r <= entry_bytes;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done          <= 1'b1;
          status        <= STATUS_MISSING;
          evicted_valid <= 1'b0;
          evicted_entry <= '0;
          last          <= 1'b1;
          state         <= ST_IDLE;
          if (cmd_ok) begin
            case (cmd_r)
              CMD_TOUCH: begin
                if (res_hit) begin
                  status <= STATUS_OK;
                end
              end
              CMD_RESERVE: begin
                if (res_hit || pend_hit) begin
                  status <= STATUS_DUP;
                end else begin
                  done  <= 1'b0;
                  state <= ST_TRIM;
                end
              end
              CMD_OK: begin
                if (pend_hit) begin
                  pending[entry_r]  <= 1'b0;
                  resident[entry_r] <= 1'b1;
                  status            <= STATUS_OK;
                end
              end
              CMD_FAIL: begin
                if (pend_hit) begin
                  pending[entry_r] <= 1'b0;
                  byte_total       <= total_sub;
                  status           <= STATUS_OK;
                end
              end
              CMD_UNLOAD: begin
                if (res_hit) begin
                  resident[entry_r] <= 1'b0;
                  byte_total        <= total_sub;
                  status            <= STATUS_OK;
                end
              end
              default: begin
                status <= STATUS_MISSING;
              end
            endcase
          end
        end
        ST_TRIM: begin
          if (trim_go) begin
            tail_r <= tail_idx;
            state  <= ST_EVICT;
          end else begin
            pending[entry_r] <= 1'b1;
            byte_total       <= total_add;
            done             <= 1'b1;
            status           <= STATUS_OK;
            evicted_valid    <= 1'b0;
            evicted_entry    <= '0;
            last             <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        ST_EVICT: begin
          resident[tail_r] <= 1'b0;
          byte_total       <= total_sub;
          done             <= 1'b1;
          status           <= STATUS_EVICT;
          evicted_valid    <= 1'b1;
          evicted_entry    <= tail_r;
          last             <= 1'b0;
          state            <= ST_TRIM;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LRUBB_ASSERT_NOW(a_mid_is_eviction, clk, rst, done && !last, evicted_valid && (status == STATUS_EVICT))
  `LRUBB_ASSERT_NOW(a_last_frees, clk, rst, done && last, !busy && !evicted_valid)
  `LRUBB_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `LRUBB_ASSERT_NOW(a_flags_disjoint, clk, rst, 1'b1, (resident & pending) == '0)

endmodule
